// ----- hw/rtl/sal_pkg.sv -----
package sal_pkg;

  // default capacity of the list
  localparam int DEPTH_DEF = 8;

  // field widths
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 31;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]   pos_t;

  // request codes; five to seven are unused
  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_VALUE = 3'd1,
    OP_DEL_POS   = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_SCAN,
    S_FETCH,
    S_SHIFT,
    S_RESP
  } state_t;

endpackage

// ----- hw/rtl/sal_req_if.sv -----
interface sal_req_if;
  logic                       valid;
  logic                       ready;
  logic [sal_pkg::OP_W-1:0]   operation;
  sal_pkg::value_t            value;
  sal_pkg::pos_t              position;

  modport source (output valid, operation, value, position, input ready);
  modport sink (input valid, operation, value, position, output ready);
endinterface

// ----- hw/rtl/sal_rsp_if.sv -----
interface sal_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sal_pkg::STATUS_W-1:0]  status;
  sal_pkg::value_t               result_value;
  sal_pkg::pos_t                 result_position;
  sal_pkg::pos_t                 entry_count;
  logic                          is_empty;
  logic                          is_full;

  modport source (
    output valid, status, result_value, result_position, entry_count, is_empty, is_full,
    input ready
  );
  modport sink (
    input valid, status, result_value, result_position, entry_count, is_empty, is_full,
    output ready
  );
endinterface

// ----- hw/rtl/sal_ram.sv -----
module sal_ram #(
  parameter int WIDTH = sal_pkg::VALUE_W,
  parameter int DEPTH = sal_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sorted_array_list_core.sv -----
// channel   | direction | beat contents
// ----------+-----------+-------------------------------------------------------
// in_req    | sink      | operation, value, position
// out_rsp   | source    | status, result_value, result_position, entry_count,
//           |           | is_empty, is_full
//
// one request at a time; the list lives in a one-read one-write ram and every
// step is one ram read per cycle, with the write of the previous step beside it
// insert walks down from the top entry, search and value delete walk up from slot zero
// synchronous active-low reset clears count and control; slots at or above the
// count are never used, so the ram needs no clearing pass
// a result beat waits in the output register; the next request is taken while
// it waits, and a stalled output only holds the sequencer in its last state
module sorted_array_list_core #(
  parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sal_req_if.sink    in_req,
  sal_rsp_if.source  out_rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int SW = CW + 1;
  localparam int XW = CW + sal_pkg::POS_W;

  sal_pkg::state_t           state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic [sal_pkg::OP_W-1:0]  op_r, op_nxt;
  sal_pkg::value_t           val_r, val_nxt;
  sal_pkg::status_t          res_status_r, res_status_nxt;
  sal_pkg::value_t           res_val_r, res_val_nxt;
  sal_pkg::pos_t             res_pos_r, res_pos_nxt;

  logic                      out_valid_r, out_valid_nxt;
  sal_pkg::status_t          out_status_r, out_status_nxt;
  sal_pkg::value_t           out_val_r, out_val_nxt;
  sal_pkg::pos_t             out_pos_r, out_pos_nxt;
  sal_pkg::pos_t             out_count_r, out_count_nxt;
  logic                      out_empty_r, out_empty_nxt;
  logic                      out_full_r, out_full_nxt;

  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  sal_pkg::value_t           mem_wdata;
  logic [IW-1:0]             mem_raddr;
  sal_pkg::value_t           mem_rdata;

  logic                      accept;
  logic                      list_full;
  logic                      list_empty;
  logic                      pos_bad;
  logic [SW-1:0]             idx_inc;
  logic [SW-1:0]             idx_inc2;
  sal_pkg::pos_t             idx_pos;
  logic                      ins_shift;
  logic                      ins_last;
  logic                      scan_hit;
  logic                      scan_last;
  logic                      shift_more;
  logic                      out_free;

  // entry storage
  sal_ram #(
    .WIDTH (sal_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake
  assign in_req.ready = (state_r == sal_pkg::S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // shared conditions
  assign list_full  = (count_r == CW'(DEPTH));
  assign list_empty = (count_r == '0);
  assign pos_bad    = (in_req.position == '0) ||
                      (XW'(in_req.position) > XW'(count_r));
  assign idx_inc    = SW'(idx_r) + SW'(1);
  assign idx_inc2   = SW'(idx_r) + SW'(2);
  assign idx_pos    = sal_pkg::POS_W'(idx_inc);
  assign ins_shift  = (mem_rdata > val_r);
  assign ins_last   = (idx_r == IW'(1));
  assign scan_hit   = (mem_rdata == val_r);
  assign scan_last  = (idx_inc == SW'(count_r));
  assign shift_more = (idx_inc2 < SW'(count_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sal_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_req.operation)
            sal_pkg::OP_INSERT: begin
              state_nxt = (list_full || list_empty) ? sal_pkg::S_RESP : sal_pkg::S_INS;
            end
            sal_pkg::OP_DEL_VALUE, sal_pkg::OP_SEARCH: begin
              state_nxt = list_empty ? sal_pkg::S_RESP : sal_pkg::S_SCAN;
            end
            sal_pkg::OP_DEL_POS, sal_pkg::OP_READ: begin
              state_nxt = (list_empty || pos_bad) ? sal_pkg::S_RESP : sal_pkg::S_FETCH;
            end
            default: begin
              state_nxt = sal_pkg::S_RESP;
            end
          endcase
        end
      end
      sal_pkg::S_INS: begin
        if (!ins_shift) begin
          state_nxt = sal_pkg::S_RESP;
        end else if (ins_last) begin
          state_nxt = sal_pkg::S_INS_PUT;
        end
      end
      sal_pkg::S_INS_PUT: begin
        state_nxt = sal_pkg::S_RESP;
      end
      sal_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_nxt = (op_r == sal_pkg::OP_DEL_VALUE && !scan_last) ?
                      sal_pkg::S_SHIFT : sal_pkg::S_RESP;
        end else if (scan_last) begin
          state_nxt = sal_pkg::S_RESP;
        end
      end
      sal_pkg::S_FETCH: begin
        state_nxt = (op_r == sal_pkg::OP_DEL_POS && !scan_last) ?
                    sal_pkg::S_SHIFT : sal_pkg::S_RESP;
      end
      sal_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_nxt = sal_pkg::S_RESP;
        end
      end
      sal_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = sal_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sal_pkg::S_IDLE;
      end
    endcase
  end

  // datapath, ram access and result
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_pos_nxt    = res_pos_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = idx_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;

    unique case (state_r)
      sal_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt         = in_req.operation;
          val_nxt        = in_req.value;
          res_status_nxt = sal_pkg::ST_MISS;
          res_val_nxt    = '0;
          res_pos_nxt    = '0;
          unique case (in_req.operation)
            sal_pkg::OP_INSERT: begin
              if (list_full) begin
                res_status_nxt = sal_pkg::ST_FULL;
              end else if (list_empty) begin
                // first entry goes straight to slot zero
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = in_req.value;
                res_status_nxt = sal_pkg::ST_OK;
                res_val_nxt    = in_req.value;
                res_pos_nxt    = sal_pkg::POS_W'(1);
                count_nxt      = count_r + CW'(1);
              end else begin
                // walk down from the top entry
                idx_nxt   = IW'(count_r);
                mem_raddr = IW'(count_r - CW'(1));
              end
            end
            sal_pkg::OP_DEL_VALUE, sal_pkg::OP_SEARCH: begin
              if (list_empty) begin
                res_status_nxt = sal_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                mem_raddr = '0;
              end
            end
            sal_pkg::OP_DEL_POS, sal_pkg::OP_READ: begin
              if (list_empty) begin
                res_status_nxt = sal_pkg::ST_EMPTY;
              end else if (!pos_bad) begin
                idx_nxt   = IW'(in_req.position - sal_pkg::POS_W'(1));
                mem_raddr = IW'(in_req.position - sal_pkg::POS_W'(1));
              end
            end
            default: begin
              res_status_nxt = sal_pkg::ST_MISS;
            end
          endcase
        end
      end
      // larger entries move up one slot while the next lower one is read
      sal_pkg::S_INS: begin
        mem_we = 1'b1;
        if (ins_shift) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - IW'(1);
          mem_raddr = idx_r - IW'(2);
        end else begin
          mem_wdata      = val_r;
          res_status_nxt = sal_pkg::ST_OK;
          res_val_nxt    = val_r;
          res_pos_nxt    = idx_pos;
          count_nxt      = count_r + CW'(1);
        end
      end
      sal_pkg::S_INS_PUT: begin
        mem_we         = 1'b1;
        mem_wdata      = val_r;
        res_status_nxt = sal_pkg::ST_OK;
        res_val_nxt    = val_r;
        res_pos_nxt    = idx_pos;
        count_nxt      = count_r + CW'(1);
      end
      // linear search for the first match
      sal_pkg::S_SCAN: begin
        mem_raddr = IW'(idx_inc);
        if (scan_hit) begin
          res_status_nxt = sal_pkg::ST_OK;
          res_val_nxt    = val_r;
          res_pos_nxt    = idx_pos;
          if (op_r == sal_pkg::OP_DEL_VALUE && scan_last) begin
            count_nxt = count_r - CW'(1);
          end
        end else if (!scan_last) begin
          idx_nxt = IW'(idx_inc);
        end
      end
      sal_pkg::S_FETCH: begin
        mem_raddr      = IW'(idx_inc);
        res_status_nxt = sal_pkg::ST_OK;
        res_val_nxt    = mem_rdata;
        res_pos_nxt    = idx_pos;
        if (op_r == sal_pkg::OP_DEL_POS && scan_last) begin
          count_nxt = count_r - CW'(1);
        end
      end
      // later entries move down one slot; write and read never hit the same slot
      sal_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        mem_raddr = IW'(idx_inc2);
        if (shift_more) begin
          idx_nxt = IW'(idx_inc);
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      sal_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt    = res_val_r;
          out_pos_nxt    = res_pos_r;
          out_count_nxt  = sal_pkg::POS_W'(count_r);
          out_empty_nxt  = list_empty;
          out_full_nxt   = list_full;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sal_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  // result beat
  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.result_value    = out_val_r;
  assign out_rsp.result_position = out_pos_r;
  assign out_rsp.entry_count     = out_count_r;
  assign out_rsp.is_empty        = out_empty_r;
  assign out_rsp.is_full         = out_full_r;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != sal_pkg::S_IDLE)
    else $error("request accepted without leaving idle");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.operation == sal_pkg::OP_INSERT && list_full
    |=> count_r == $past(count_r))
    else $error("insert into full list changed the count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != sal_pkg::ST_OK
    |-> out_val_r == '0 && out_pos_r == '0)
    else $error("failed request carries value or position");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sal_pkg::S_SHIFT |-> idx_inc2 <= SW'(count_r))
    else $error("shift reads beyond the last entry");

endmodule
